// ===== src/debounced_keypad_with_shift_router_macros.svh =====
// Assertion macros shared by the keypad router RTL.
`ifndef DEBOUNCED_KEYPAD_WITH_SHIFT_ROUTER_MACROS_SVH
`define DEBOUNCED_KEYPAD_WITH_SHIFT_ROUTER_MACROS_SVH

// same-cycle implication
`define DKS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define DKS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/dks_pkg.sv =====
// Shared types and constants of the debounced keypad router.
package dks_pkg;

	localparam int ROWS  = 4;
	localparam int COLS  = 4;
	localparam int NKEYS = ROWS * COLS;
	localparam int KW    = $clog2(NKEYS);

	localparam logic [7:0]  DEBOUNCE_RESET   = 8'd5;
	localparam logic [15:0] SHIFT_HOLD_RESET = 16'd400;

	localparam logic [1:0] CFG_DEBOUNCE   = 2'd0;
	localparam logic [1:0] CFG_SHIFT_HOLD = 2'd1;

	localparam logic [3:0] EV_STATUS  = 4'd0;
	localparam logic [3:0] EV_CLICK   = 4'd1;
	localparam logic [3:0] EV_STEP    = 4'd2;
	localparam logic [3:0] EV_NOTE    = 4'd3;
	localparam logic [3:0] EV_PLAY    = 4'd4;
	localparam logic [3:0] EV_UIPAGE  = 4'd5;
	localparam logic [3:0] EV_TRACK   = 4'd6;
	localparam logic [3:0] EV_MUTE    = 4'd7;
	localparam logic [3:0] EV_FIELD   = 4'd8;
	localparam logic [3:0] EV_PAGESET = 4'd9;

	localparam logic [1:0] PAGE_STEP = 2'd0;
	localparam logic [1:0] PAGE_NOTE = 2'd1;
	localparam logic [1:0] PAGE_CTRL = 2'd2;

	localparam logic [KW-1:0] KEY_PAGE_STEP = KW'(3);
	localparam logic [KW-1:0] KEY_PAGE_NOTE = KW'(7);
	localparam logic [KW-1:0] KEY_PAGE_CTRL = KW'(11);
	localparam logic [KW-1:0] KEY_PLAY      = KW'(0);
	localparam logic [KW-1:0] KEY_UIPAGE    = KW'(1);
	localparam logic [KW-1:0] KEY_TRACK     = KW'(2);
	localparam logic [KW-1:0] KEY_MUTE      = KW'(4);
	localparam logic [KW-1:0] KEY_FIELD     = KW'(5);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_UPD,
		ST_SCAN,
		ST_STAT
	} state_t;

	typedef struct packed {
		logic          load;
		logic          upd;
		logic          scan;
		logic          stat;
		logic [KW-1:0] idx;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} sts_t;

endpackage

// ===== src/dks_ctrl.sv =====
// Sequencer: tick load, switch/key update, key scan, status.
module dks_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  dks_pkg::sts_t   sts,
	output dks_pkg::cmd_t   cmd
);

	dks_pkg::state_t             state_q, state_n;
	logic [dks_pkg::KW-1:0]      idx_q, idx_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dks_pkg::ST_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_n;
			idx_q   <= idx_n;
		end
	end

	always_comb begin
		state_n  = state_q;
		idx_n    = idx_q;
		cmd      = '0;
		cmd.idx  = idx_q;
		in_stall = (state_q != dks_pkg::ST_IDLE);
		unique case (state_q)
			dks_pkg::ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_n  = dks_pkg::ST_UPD;
				end
			end
			dks_pkg::ST_UPD: begin
				if (sts.out_free) begin
					cmd.upd = 1'b1;
					idx_n   = '0;
					state_n = dks_pkg::ST_SCAN;
				end
			end
			dks_pkg::ST_SCAN: begin
				if (sts.out_free) begin
					cmd.scan = 1'b1;
					if (idx_q == dks_pkg::KW'(dks_pkg::NKEYS - 1)) begin
						state_n = dks_pkg::ST_STAT;
					end else begin
						idx_n = idx_q + 1'b1;
					end
				end
			end
			dks_pkg::ST_STAT: begin
				if (sts.out_free) begin
					cmd.stat = 1'b1;
					state_n  = dks_pkg::ST_IDLE;
				end
			end
			default: state_n = dks_pkg::ST_IDLE;
		endcase
	end

endmodule

// ===== src/dks_dp.sv =====
// Datapath: debounce state, shift and page registers, event routing, result register.
module dks_dp (
	input  logic                      clk,
	input  logic                      arst_n,
	input  dks_pkg::cmd_t             cmd,
	output dks_pkg::sts_t             sts,
	input  logic                      cfg_we,
	input  logic [1:0]                cfg_index,
	input  logic [15:0]               cfg_data,
	input  logic                      switch_released,
	input  logic [dks_pkg::NKEYS-1:0] keys_pressed,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [3:0]                event_code,
	output logic [3:0]                key_index,
	output logic                      shift_held,
	output logic [1:0]                keypad_page,
	output logic                      last
);

	localparam int N = dks_pkg::NKEYS;

	logic [7:0]   debounce_q;
	logic [15:0]  shift_hold_q;

	logic         raw_sw_q;
	logic [N-1:0] raw_keys_q;

	logic         sw_stable_q, sw_last_q;
	logic [7:0]   sw_quiet_q;
	logic [15:0]  press_time_q;
	logic         shift_q;
	logic [1:0]   page_q;
	logic [N-1:0] key_stable_q, key_last_q, edge_q;
	logic [7:0]   key_quiet_q [N];

	logic         out_valid_q;

	// switch update
	logic         sw_last_n, sw_stable_n, shift_n, click, sw_acc;
	logic [7:0]   sw_quiet_n;
	logic [15:0]  press_time_n;

	// key update
	logic [N-1:0] key_stable_n, key_last_n, edge_n;
	logic [7:0]   key_quiet_n [N];

	// routing
	logic         route_emit;
	logic [3:0]   route_code;
	logic [3:0]   route_key;
	logic [1:0]   route_page;
	logic         edge_hit;

	// emission
	logic         emit;
	logic [3:0]   ev_code, ev_key;
	logic         ev_shift, ev_last;
	logic [1:0]   ev_page;

	assign sts.out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q   <= dks_pkg::DEBOUNCE_RESET;
			shift_hold_q <= dks_pkg::SHIFT_HOLD_RESET;
		end else if (cfg_we) begin
			if (cfg_index == dks_pkg::CFG_DEBOUNCE) begin
				debounce_q <= cfg_data[7:0];
			end else if (cfg_index == dks_pkg::CFG_SHIFT_HOLD) begin
				shift_hold_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			raw_sw_q   <= switch_released;
			raw_keys_q <= keys_pressed;
		end
	end

	always_comb begin
		press_time_n = (press_time_q == 16'hFFFF) ? press_time_q : press_time_q + 16'd1;
		if (raw_sw_q != sw_last_q) begin
			sw_last_n  = raw_sw_q;
			sw_quiet_n = 8'd0;
		end else begin
			sw_last_n  = sw_last_q;
			sw_quiet_n = (sw_quiet_q == 8'hFF) ? sw_quiet_q : sw_quiet_q + 8'd1;
		end
		sw_acc      = (sw_quiet_n >= debounce_q) && (raw_sw_q != sw_stable_q);
		sw_stable_n = sw_acc ? raw_sw_q : sw_stable_q;
		shift_n     = shift_q;
		click       = 1'b0;
		if (sw_acc) begin
			shift_n = 1'b0;
			if (!raw_sw_q) begin
				press_time_n = 16'd0;
			end else begin
				click = !shift_q;
			end
		end
		if (!sw_stable_n && !shift_n && (press_time_n >= shift_hold_q)) begin
			shift_n = 1'b1;
		end
	end

	always_comb begin
		for (int k = 0; k < N; k++) begin
			if (raw_keys_q[k] != key_last_q[k]) begin
				key_last_n[k]  = raw_keys_q[k];
				key_quiet_n[k] = 8'd0;
			end else begin
				key_last_n[k]  = key_last_q[k];
				key_quiet_n[k] = (key_quiet_q[k] == 8'hFF) ? key_quiet_q[k]
					: key_quiet_q[k] + 8'd1;
			end
			if ((key_quiet_n[k] >= debounce_q) && (raw_keys_q[k] != key_stable_q[k])) begin
				key_stable_n[k] = raw_keys_q[k];
				edge_n[k]       = raw_keys_q[k];
			end else begin
				key_stable_n[k] = key_stable_q[k];
				edge_n[k]       = 1'b0;
			end
		end
	end

	assign edge_hit = edge_q[cmd.idx];

	always_comb begin
		route_emit = 1'b0;
		route_code = dks_pkg::EV_STATUS;
		route_key  = 4'd0;
		route_page = page_q;
		if (shift_q) begin
			route_code = dks_pkg::EV_PAGESET;
			if (cmd.idx == dks_pkg::KEY_PAGE_STEP) begin
				route_emit = 1'b1;
				route_page = dks_pkg::PAGE_STEP;
			end else if (cmd.idx == dks_pkg::KEY_PAGE_NOTE) begin
				route_emit = 1'b1;
				route_page = dks_pkg::PAGE_NOTE;
			end else if (cmd.idx == dks_pkg::KEY_PAGE_CTRL) begin
				route_emit = 1'b1;
				route_page = dks_pkg::PAGE_CTRL;
			end
		end else begin
			unique case (page_q)
				dks_pkg::PAGE_STEP: begin
					route_emit = 1'b1;
					route_code = dks_pkg::EV_STEP;
					route_key  = 4'(cmd.idx);
				end
				dks_pkg::PAGE_NOTE: begin
					route_emit = 1'b1;
					route_code = dks_pkg::EV_NOTE;
					route_key  = 4'(cmd.idx);
				end
				dks_pkg::PAGE_CTRL: begin
					route_emit = 1'b1;
					unique case (cmd.idx)
						dks_pkg::KEY_PLAY:   route_code = dks_pkg::EV_PLAY;
						dks_pkg::KEY_UIPAGE: route_code = dks_pkg::EV_UIPAGE;
						dks_pkg::KEY_TRACK:  route_code = dks_pkg::EV_TRACK;
						dks_pkg::KEY_MUTE:   route_code = dks_pkg::EV_MUTE;
						dks_pkg::KEY_FIELD:  route_code = dks_pkg::EV_FIELD;
						default:             route_emit = 1'b0;
					endcase
				end
				default: route_emit = 1'b0;
			endcase
		end
	end

	always_comb begin
		emit     = 1'b0;
		ev_code  = dks_pkg::EV_STATUS;
		ev_key   = 4'd0;
		ev_shift = shift_q;
		ev_page  = page_q;
		ev_last  = 1'b0;
		priority if (cmd.upd) begin
			emit     = click;
			ev_code  = dks_pkg::EV_CLICK;
			ev_shift = shift_n;
		end else if (cmd.scan) begin
			emit    = edge_hit && route_emit;
			ev_code = route_code;
			ev_key  = route_key;
			ev_page = route_page;
		end else if (cmd.stat) begin
			emit    = 1'b1;
			ev_last = 1'b1;
		end else begin
			emit    = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sw_stable_q  <= 1'b1;
			sw_last_q    <= 1'b1;
			sw_quiet_q   <= 8'd0;
			press_time_q <= 16'd0;
			shift_q      <= 1'b0;
			page_q       <= dks_pkg::PAGE_STEP;
			key_stable_q <= '0;
			key_last_q   <= '0;
			edge_q       <= '0;
			for (int k = 0; k < N; k++) begin
				key_quiet_q[k] <= 8'd0;
			end
		end else begin
			if (cmd.upd) begin
				sw_stable_q  <= sw_stable_n;
				sw_last_q    <= sw_last_n;
				sw_quiet_q   <= sw_quiet_n;
				press_time_q <= press_time_n;
				shift_q      <= shift_n;
				key_stable_q <= key_stable_n;
				key_last_q   <= key_last_n;
				edge_q       <= edge_n;
				for (int k = 0; k < N; k++) begin
					key_quiet_q[k] <= key_quiet_n[k];
				end
			end
			if (cmd.scan && edge_hit && route_emit) begin
				page_q <= route_page;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			event_code  <= ev_code;
			key_index   <= ev_key;
			shift_held  <= ev_shift;
			keypad_page <= ev_page;
			last        <= ev_last;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== src/debounced_keypad_with_shift_router.sv =====
// Top level of the debounced keypad scanner with shift router.
//
// Input channel: in_valid/in_stall carry one millisecond tick (switch_released,
// keys_pressed). A tick is taken while the block is idle; in_stall stays high
// from the cycle after acceptance until the tick's status result is loaded.
// Output channel: out_valid/out_stall carry the events of the tick (optional
// click, one event per routed key press, in key order) and then a status
// request with last set. Results leave through one output register.
// Sequence: the tick is loaded, then the switch/key update (which may emit the
// click), then the key scan in key order (which emits the routed key events),
// then the status request. The serial key scan sets the rate. While out_stall
// holds the output register full, the sequencer waits in place and loses nothing.
// Config: cfg_valid/cfg_ready write register cfg_index (0 debounce time,
// 1 shift hold time) with cfg_data; cfg_ready is always high, writes to other
// indexes are ignored. Writes are expected only while idle.
// Reset (arst_n low) returns all debounce state, shift, page and the config
// registers to their defaults and empties the output register.
`include "debounced_keypad_with_shift_router_macros.svh"

module debounced_keypad_with_shift_router (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      switch_released,
	input  logic [dks_pkg::NKEYS-1:0] keys_pressed,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [3:0]                event_code,
	output logic [3:0]                key_index,
	output logic                      shift_held,
	output logic [1:0]                keypad_page,
	output logic                      last,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [1:0]                cfg_index,
	input  logic [15:0]               cfg_data
);

	dks_pkg::cmd_t cmd;
	dks_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	dks_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	dks_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.cfg_we          (cfg_valid && cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.switch_released (switch_released),
		.keys_pressed    (keys_pressed),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.event_code      (event_code),
		.key_index       (key_index),
		.shift_held      (shift_held),
		.keypad_page     (keypad_page),
		.last            (last)
	);

	`DKS_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall, in_stall, "tick accepted but block not busy")
	`DKS_ASSERT_NOW(a_last_is_status, clk, arst_n, out_valid && last, event_code == dks_pkg::EV_STATUS, "last result is not a status request")
	`DKS_ASSERT_NOW(a_event_before_status, clk, arst_n, out_valid && !last, in_stall, "event pending while block idle")
	`DKS_ASSERT_NOW(a_page_range, clk, arst_n, out_valid, keypad_page != 2'd3, "invalid keypad page")

endmodule
